// File: hw/rtl/idc_pkg.sv
// ----------------------------------------------------------------------------
// idc_pkg: shared definitions for the interval displacement cost block
// Default sizes, fixed field widths and the codes that the rule unit returns.
// ----------------------------------------------------------------------------
package idc_pkg;

  // Default configuration of the interval store.
  localparam int MaxIntervalsDef = 64;
  localparam int PosBitsDef      = 16;

  // Fixed widths of the port fields.
  localparam int InPosW   = 16;
  localparam int IdxOutW  = 6;
  localparam int CostW    = 7;

  // Contribution of one other interval to a cost: -1, 0 or +1.
  typedef logic signed [1:0] rule_t;

  localparam rule_t RULE_ZERO  = 2'sd0;
  localparam rule_t RULE_PLUS  = 2'sd1;
  localparam rule_t RULE_MINUS = -2'sd1;

endpackage

// File: hw/rtl/idc_rule.sv
// ----------------------------------------------------------------------------
// idc_rule: pairwise displacement rule
// Compares a subject interval with one other interval and gives its
// contribution to the subject's cost.
// ----------------------------------------------------------------------------
module idc_rule
  import idc_pkg::*;
#(
  parameter int PosBits = PosBitsDef
) (
  input  logic [PosBits-1:0] subj_start_i,
  input  logic [PosBits-1:0] subj_end_i,
  input  logic [PosBits-1:0] oth_start_i,
  input  logic [PosBits-1:0] oth_end_i,
  output rule_t              rule_o
);

  logic [PosBits-1:0] s1, s2, o1, o2;

  assign s1 = subj_start_i;
  assign s2 = subj_end_i;
  assign o1 = oth_start_i;
  assign o2 = oth_end_i;

  always_comb begin
    rule_o = RULE_ZERO;
    if (s1 == s2 || o1 == o2) begin
      rule_o = RULE_ZERO;
    end else if (s1 < s2) begin
      if (o1 < o2) begin
        if (s1 < o1) begin
          if (s2 >= o1 && s2 < o2) rule_o = RULE_PLUS;
        end else if (s1 > o1 && s1 < o2) begin
          if (s2 >= o2) rule_o = RULE_MINUS;
        end
      end else if (s2 == o2) begin
        rule_o = RULE_PLUS;
      end else if (s2 > o2) begin
        if (s2 > o1) begin
          rule_o = RULE_ZERO;
        end else if (s2 == o1) begin
          rule_o = RULE_MINUS;
        end else begin
          rule_o = RULE_PLUS;
        end
      end
    end else if (o1 < o2) begin
      // Backward subject against a forward interval.
      if (s1 > o1 && s1 <= o2) rule_o = RULE_MINUS;
    end else begin
      // Backward subject against a backward interval.
      if (s1 > o2 && s1 < o1) rule_o = RULE_MINUS;
    end
  end

endmodule

// File: hw/rtl/interval_displacement_cost.sv
// ----------------------------------------------------------------------------
// interval_displacement_cost: per-interval displacement cost over a set
// Loading accepts one interval per transfer. After the final interval each cost
// is built in order: subject read, subject capture, every stored interval
// through the single rule unit, and an output state held until the result is
// taken. Reset clears the count, drop flag and sequencer; the stores are not
// cleared.
// ----------------------------------------------------------------------------
module interval_displacement_cost
  import idc_pkg::*;
#(
  parameter int MaxIntervals = MaxIntervalsDef,
  parameter int PosBits      = PosBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Input channel: one interval per transfer.
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [InPosW-1:0]        interval_start_i,
  input  logic [InPosW-1:0]        interval_end_i,
  input  logic                     is_final_i,
  // Output channel: one cost per stored interval, in load order.
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [IdxOutW-1:0]       interval_index_o,
  output logic signed [CostW-1:0]  cost_o,
  output logic                     end_of_run_o,
  output logic                     dropped_o
);

  // Index into the store, and a count that can also hold the full depth.
  localparam int IdxW = (MaxIntervals > 1) ? $clog2(MaxIntervals) : 1;
  localparam int CntW = $clog2(MaxIntervals + 1);

  // The sequencer walks subject k over the set. For each subject it reads
  // the subject entry, then streams every other entry through the rule unit
  // one per cycle: the memory read of entry j+1 overlaps the rule evaluation
  // of entry j.
  typedef enum logic [2:0] {
    S_LOAD,  // accepting intervals
    S_SUBJ,  // read of the subject entry in flight
    S_SCAP,  // capture subject, read of the first other entry in flight
    S_ACC,   // accumulate one other entry per cycle
    S_OUT    // result waiting for its transfer
  } state_e;

  state_e state_q;

  logic [CntW-1:0]          count_q;
  logic                     ovf_q;
  logic [IdxW-1:0]          k_q;
  logic [IdxW-1:0]          j_q;
  logic signed [CostW-1:0]  acc_q;
  logic [PosBits-1:0]       subj_start_q, subj_end_q;

  // Interval store: one write port for loading, one registered read port.
  logic [PosBits-1:0] start_mem [MaxIntervals];
  logic [PosBits-1:0] end_mem   [MaxIntervals];
  logic [PosBits-1:0] rd_start_q, rd_end_q;
  logic [IdxW-1:0]    rd_addr;
  logic [IdxW-1:0]    j_next;

  logic in_xfer, out_xfer, store_full, do_write, last_other, last_subj;
  rule_t rule_val;

  assign in_ready_o  = (state_q == S_LOAD);
  assign in_xfer     = in_valid_i & in_ready_o;
  assign out_valid_o = (state_q == S_OUT);
  assign out_xfer    = out_valid_o & out_ready_i;

  assign store_full = (count_q == CntW'(MaxIntervals));
  assign do_write   = in_xfer & ~store_full;

  assign j_next     = j_q + IdxW'(1);
  assign last_other = ((CntW'(j_q) + CntW'(1)) == count_q);
  assign last_subj  = ((CntW'(k_q) + CntW'(1)) == count_q);

  always_comb begin
    case (state_q)
      S_SUBJ:  rd_addr = k_q;
      S_SCAP:  rd_addr = '0;
      S_ACC:   rd_addr = j_next;
      default: rd_addr = k_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      start_mem[count_q[IdxW-1:0]] <= PosBits'(interval_start_i);
      end_mem[count_q[IdxW-1:0]]   <= PosBits'(interval_end_i);
    end
    rd_start_q <= start_mem[rd_addr];
    rd_end_q   <= end_mem[rd_addr];
  end

  idc_rule #(
    .PosBits (PosBits)
  ) u_rule (
    .subj_start_i (subj_start_q),
    .subj_end_i   (subj_end_q),
    .oth_start_i  (rd_start_q),
    .oth_end_i    (rd_end_q),
    .rule_o       (rule_val)
  );

  // Sequencer, counters and accumulator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      count_q      <= '0;
      ovf_q        <= 1'b0;
      k_q          <= '0;
      j_q          <= '0;
      acc_q        <= '0;
      subj_start_q <= '0;
      subj_end_q   <= '0;
    end else begin
      case (state_q)
        S_LOAD: begin
          if (in_xfer) begin
            // An interval beyond the store depth is discarded and flagged;
            // a discarded final interval still starts the computation.
            if (store_full) begin
              ovf_q <= 1'b1;
            end else begin
              count_q <= count_q + CntW'(1);
            end
            if (is_final_i) begin
              k_q     <= '0;
              state_q <= S_SUBJ;
            end
          end
        end
        S_SUBJ: begin
          state_q <= S_SCAP;
        end
        S_SCAP: begin
          subj_start_q <= rd_start_q;
          subj_end_q   <= rd_end_q;
          acc_q        <= '0;
          j_q          <= '0;
          state_q      <= S_ACC;
        end
        S_ACC: begin
          // The subject itself is skipped.
          if (j_q != k_q) begin
            acc_q <= acc_q + CostW'(rule_val);
          end
          if (last_other) begin
            state_q <= S_OUT;
          end else begin
            j_q <= j_next;
          end
        end
        S_OUT: begin
          if (out_xfer) begin
            if (last_subj) begin
              // Set complete: the store is emptied and the drop flag cleared.
              count_q <= '0;
              ovf_q   <= 1'b0;
              state_q <= S_LOAD;
            end else begin
              k_q     <= k_q + IdxW'(1);
              state_q <= S_SUBJ;
            end
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  assign interval_index_o = IdxOutW'(k_q);
  assign cost_o           = acc_q;
  assign end_of_run_o     = last_subj;
  assign dropped_o        = ovf_q;

  // A result is only shown when at least one interval is stored.
  a_out_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_q != '0))
    else $error("result offered with an empty store");

  // The streamed entry never runs past the loaded set.
  a_other_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) |-> (CntW'(j_q) < count_q))
    else $error("other index beyond the loaded count");

  // The count never exceeds the store depth.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxIntervals))
    else $error("interval count beyond store depth");

  // The transfer of the last result empties the store and clears the flag.
  a_clear_after_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && end_of_run_o) |=> (count_q == '0 && !ovf_q && in_ready_o))
    else $error("store not emptied after the last result");

endmodule
